### rtl/sse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sse_pkg: shared types and helpers of the Shift-JIS string extractor
// Byte classes, job format between front and back, UTF-8 encoding of
// half-width katakana, configuration register codes.
// ----------------------------------------------------------------------------
package sse_pkg;

	localparam int MIN_RUN = 4;
	localparam int HOLD    = MIN_RUN - 1;
	localparam int HOLD_W  = (HOLD > 1) ? $clog2(HOLD) : 1;
	localparam int RUN_W   = $clog2(MIN_RUN + 1);
	localparam int NSLOT   = MIN_RUN + 1;
	localparam int SLOT_W  = $clog2(NSLOT);
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int QCW     = $clog2(QDEPTH + 1);

	localparam logic [7:0] STR_CAP_RST      = 8'd16;
	localparam logic [7:0] OUTPUT_LIMIT_RST = 8'd253;
	localparam logic [7:0] QMARK            = 8'h3F;

	localparam logic CFG_STR_CAP      = 1'b0;
	localparam logic CFG_OUTPUT_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		JOB_CHAR,
		JOB_KANA,
		JOB_TERM
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  data;
		logic [7:0]  index;
		logic        last;
	} job_t;

	function automatic logic is_ascii(input logic [7:0] b);
		return (b >= 8'h20) && (b <= 8'h7E);
	endfunction

	function automatic logic is_kana(input logic [7:0] b);
		return (b >= 8'hA1) && (b <= 8'hDF);
	endfunction

	function automatic logic is_text(input logic [7:0] b);
		return is_ascii(b) || is_kana(b) || ((b >= 8'h81) && (b <= 8'h9F)) ||
			((b >= 8'hE0) && (b <= 8'hEF));
	endfunction

	function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [1:0] add);
		logic [8:0] s;
		s = {1'b0, c} + {7'd0, add};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	// UTF-8 byte of U+FF61 + (b - 0xA1), phase 0..2
	function automatic logic [7:0] kana_byte(input logic [7:0] b, input logic [1:0] phase);
		logic [15:0] cp;
		logic [7:0]  r;
		cp = 16'hFF61 + {8'h00, b} - 16'h00A1;
		case (phase)
			2'd0:    r = 8'hE0 | {4'h0, cp[15:12]};
			2'd1:    r = 8'h80 | {2'b00, cp[11:6]};
			default: r = 8'h80 | {2'b00, cp[5:0]};
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/sse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sse_front: input acceptance and run tracking
// Classifies each byte, tracks the run, holds back early run bytes and plans
// the character and terminator jobs of one transaction into a slot buffer
// that drains into the job queue one job per cycle unless the queue is full.
// ----------------------------------------------------------------------------
module sse_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [7:0]           data_byte,
	input  wire                  end_of_data,
	input  wire                  cfg_we,
	input  wire                  cfg_index,
	input  wire  [7:0]           cfg_data,
	input  wire                  q_full,
	output logic                 q_push,
	output sse_pkg::job_t        q_job
);

	logic [7:0] str_cap_q, output_limit_q;

	logic [sse_pkg::RUN_W-1:0] run_q, run_n;
	logic                      skip_q, skip_n;
	logic [7:0]                cnt_q, cnt_n;
	logic [7:0]                sf_q, sf_n;
	logic                      fin_q, fin_n;
	logic [7:0]                pend_q [sse_pkg::HOLD];

	logic [sse_pkg::NSLOT-1:0] vld_q, vld_n, plan_v, push_mask;
	sse_pkg::job_kind_t        kind_q [sse_pkg::NSLOT];
	logic [7:0]                data_q [sse_pkg::NSLOT];
	sse_pkg::job_kind_t        plan_k [sse_pkg::NSLOT];
	logic [7:0]                plan_d [sse_pkg::NSLOT];
	logic [7:0]                idx_q;

	logic                      pend_we;
	logic                      accept;
	logic [sse_pkg::SLOT_W-1:0] sel;
	logic [sse_pkg::NSLOT-1:0] above;

	// plan one transaction
	always_comb begin
		logic                      txt, do_end;
		logic [7:0]                cb   [sse_pkg::MIN_RUN];
		logic [sse_pkg::MIN_RUN-1:0] want;
		run_n   = run_q;
		skip_n  = skip_q;
		cnt_n   = cnt_q;
		sf_n    = sf_q;
		fin_n   = fin_q;
		pend_we = 1'b0;
		want    = '0;
		plan_v  = '0;
		do_end  = 1'b0;
		txt     = sse_pkg::is_text(data_byte);
		for (int k = 0; k < sse_pkg::HOLD; k++) begin
			cb[k] = pend_q[k];
		end
		cb[sse_pkg::HOLD] = data_byte;
		for (int k = 0; k < sse_pkg::NSLOT; k++) begin
			plan_k[k] = sse_pkg::JOB_CHAR;
			plan_d[k] = data_byte;
		end
		plan_k[sse_pkg::MIN_RUN] = sse_pkg::JOB_TERM;
		plan_d[sse_pkg::MIN_RUN] = 8'h00;

		if (!fin_q) begin
			if (txt) begin
				if (run_q == '0 && sf_q >= str_cap_q) begin
					fin_n = 1'b1;
				end else if (run_q >= sse_pkg::RUN_W'(sse_pkg::MIN_RUN)) begin
					want[sse_pkg::HOLD] = 1'b1;
				end else if (run_q < sse_pkg::RUN_W'(sse_pkg::HOLD)) begin
					pend_we = 1'b1;
					run_n   = run_q + 1'b1;
				end else begin
					want  = '1;
					run_n = sse_pkg::RUN_W'(sse_pkg::MIN_RUN);
				end
			end else begin
				do_end = 1'b1;
			end
		end

		for (int k = 0; k < sse_pkg::MIN_RUN; k++) begin
			if (want[k]) begin
				if (skip_n) begin
					skip_n = 1'b0;
				end else if (cnt_n < output_limit_q) begin
					plan_v[k] = 1'b1;
					plan_d[k] = cb[k];
					if (sse_pkg::is_ascii(cb[k])) begin
						cnt_n = sse_pkg::sat_add(cnt_n, 2'd1);
					end else if (sse_pkg::is_kana(cb[k])) begin
						plan_k[k] = sse_pkg::JOB_KANA;
						cnt_n     = sse_pkg::sat_add(cnt_n, 2'd3);
					end else begin
						plan_d[k] = sse_pkg::QMARK;
						cnt_n     = sse_pkg::sat_add(cnt_n, 2'd1);
						skip_n    = 1'b1;
					end
				end
			end
		end

		if (end_of_data && !fin_n) do_end = 1'b1;
		if (do_end) begin
			if (run_n >= sse_pkg::RUN_W'(sse_pkg::MIN_RUN)) begin
				plan_v[sse_pkg::MIN_RUN] = 1'b1;
				sf_n = sf_n + 8'd1;
				if (sf_n >= str_cap_q) fin_n = 1'b1;
			end
			run_n  = '0;
			skip_n = 1'b0;
			cnt_n  = '0;
		end
		if (end_of_data) begin
			run_n  = '0;
			skip_n = 1'b0;
			cnt_n  = '0;
			sf_n   = '0;
			fin_n  = 1'b0;
		end
	end

	// pick the oldest pending slot
	always_comb begin
		sel = '0;
		for (int k = sse_pkg::NSLOT - 1; k >= 0; k--) begin
			if (vld_q[k]) sel = sse_pkg::SLOT_W'(k);
		end
		above = (vld_q >> sel) >> 1;
	end

	assign q_push    = (|vld_q) && !q_full;
	assign push_mask = q_push ? (sse_pkg::NSLOT'(1) << sel) : '0;
	assign in_stall  = |(vld_q & ~push_mask);
	assign accept    = in_valid && !in_stall;
	assign q_job     = '{kind: kind_q[sel], data: data_q[sel], index: idx_q,
		last: (above == '0)};

	always_comb begin
		vld_n = vld_q & ~push_mask;
		if (accept) vld_n = plan_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_cap_q      <= sse_pkg::STR_CAP_RST;
			output_limit_q <= sse_pkg::OUTPUT_LIMIT_RST;
			run_q          <= '0;
			skip_q         <= 1'b0;
			cnt_q          <= '0;
			sf_q           <= '0;
			fin_q          <= 1'b0;
			vld_q          <= '0;
		end else begin
			vld_q <= vld_n;
			if (accept) begin
				run_q  <= run_n;
				skip_q <= skip_n;
				cnt_q  <= cnt_n;
				sf_q   <= sf_n;
				fin_q  <= fin_n;
			end
			if (cfg_we) begin
				case (cfg_index)
					sse_pkg::CFG_STR_CAP:      str_cap_q      <= cfg_data;
					sse_pkg::CFG_OUTPUT_LIMIT: output_limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= sf_q;
			for (int k = 0; k < sse_pkg::NSLOT; k++) begin
				kind_q[k] <= plan_k[k];
				data_q[k] <= plan_d[k];
			end
			if (pend_we) pend_q[run_q[sse_pkg::HOLD_W-1:0]] <= data_byte;
		end
	end

endmodule
`default_nettype wire

### rtl/sse_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sse_queue: job queue between front and back
// Small register FIFO that lets the planner and the byte serializer stall
// independently.
// ----------------------------------------------------------------------------
module sse_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  sse_pkg::job_t        push_job,
	output logic                 full,
	input  wire                  pop,
	output logic                 head_valid,
	output sse_pkg::job_t        head_job
);

	sse_pkg::job_t             mem_q [sse_pkg::QDEPTH];
	logic [sse_pkg::QAW-1:0]   wr_q, rd_q;
	logic [sse_pkg::QCW-1:0]   count_q;
	logic                      do_push, do_pop;

	assign full       = (count_q == sse_pkg::QCW'(sse_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

endmodule
`default_nettype wire

### rtl/sse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sse_back: UTF-8 byte serializer
// Takes jobs from the queue head and drives one output byte per cycle into
// the output register while out_stall is low; a kana job yields three bytes.
// ----------------------------------------------------------------------------
module sse_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  sse_pkg::job_t        head_job,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [7:0]           out_byte,
	output logic [7:0]           string_index,
	output logic                 end_of_string,
	output logic                 last
);

	logic [1:0] phase_q;
	logic       out_valid_q;
	logic       load, fin_phase;
	logic [7:0] byte_n;

	always_comb begin
		fin_phase = 1'b1;
		case (head_job.kind)
			sse_pkg::JOB_CHAR: byte_n = head_job.data;
			sse_pkg::JOB_KANA: begin
				byte_n    = sse_pkg::kana_byte(head_job.data, phase_q);
				fin_phase = (phase_q == 2'd2);
			end
			sse_pkg::JOB_TERM: byte_n = 8'h00;
			default:           byte_n = 8'h00;
		endcase
	end

	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load && fin_phase;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= fin_phase ? 2'd0 : phase_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte      <= byte_n;
			string_index  <= head_job.index;
			end_of_string <= (head_job.kind == sse_pkg::JOB_TERM);
			last          <= head_job.last && fin_phase;
		end
	end

endmodule
`default_nettype wire

### rtl/sjis_string_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjis_string_extractor: Shift-JIS text run extractor with UTF-8 output
// Input channel in_valid/in_stall carries one raw byte and an end-of-buffer
// flag per transaction. Output channel out_valid/out_stall carries one UTF-8
// byte, its string index, a terminator flag and a last-of-input flag.
// Configuration: cfg_we with cfg_index 0 = string count cap, 1 = output_limit;
// the user must see it is written only while idle; the block does not
// enforce this. A write takes effect from the next input byte. A result is
// held in the front's slot buffer, the job queue and the output register.
// Throughput: one input per cycle while each byte yields at most one job and
// the queue takes it; a run that qualifies flushes up to five jobs into the
// queue, one per cycle while it is not full. The output register emits one
// byte per cycle while out_stall is low, and a katakana yields three bytes.
// Reset clears the run state and string count and restores the register
// defaults (16, 253). When out_stall is high the output holds; the four-entry
// job queue fills and then the input side stalls.
// ----------------------------------------------------------------------------
module sjis_string_extractor (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] data_byte,
	input  wire        end_of_data,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire  [7:0] cfg_data,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_byte,
	output logic [7:0] string_index,
	output logic       end_of_string,
	output logic       last
);

	logic          q_push, q_full, q_pop, head_valid;
	sse_pkg::job_t push_job, head_job;

	sse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	sse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	sse_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.string_index  (string_index),
		.end_of_string (end_of_string),
		.last          (last)
	);

endmodule
`default_nettype wire
